>>> hw/rtl/psr_pkg.sv
// Shared constants and types for the perfect square remover.
package psr_pkg;

    localparam int MaxItems = 1024;
    localparam int CntW     = 11;
    localparam int CntLimit = (1 << CntW) - 1;
    localparam int CountCap = (MaxItems > CntLimit) ? CntLimit : MaxItems;

    localparam int ValW     = 32;
    localparam int NumCells = ValW / 2;
    localparam int RootW    = NumCells;
    localparam int RemW     = RootW + 2;

    // Payload handed from one root cell to the next.
    typedef struct packed {
        logic [ValW-1:0]  value;
        logic             last;
        logic             neg;
        logic [ValW-1:0]  rad;   // radicand bits still to be consumed, msb first
        logic [RemW-1:0]  rem;
        logic [RootW-1:0] root;
    } cell_data_t;

endpackage

>>> hw/rtl/psr_ifs.sv
// Request and result channels of the perfect square remover.
interface psr_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface psr_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_out;
    logic               has_value;
    logic               end_of_list;
    logic [10:0]        removed_total;
    logic               none_left;

    modport source (output valid, output value_out, output has_value, output end_of_list,
                    output removed_total, output none_left, input ready);
    modport sink   (input valid, input value_out, input has_value, input end_of_list,
                    input removed_total, input none_left, output ready);
endinterface

>>> hw/rtl/psr_cell.sv
// One root digit cell: consumes two radicand bits, yields one root bit.
module psr_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                valid_in,
    input  psr_pkg::cell_data_t data_in,
    output logic                valid_out,
    output psr_pkg::cell_data_t data_out
);
    import psr_pkg::*;

    logic             valid_reg;
    cell_data_t       data_reg;
    cell_data_t       data_next;
    logic [RemW+1:0]  rem_sh;
    logic [RemW+1:0]  trial;
    logic [RemW+1:0]  diff;
    logic             ge;

    always_comb
    begin
        rem_sh = {data_in.rem, data_in.rad[ValW-1 -: 2]};
        trial  = {2'b00, data_in.root, 2'b01};
        ge     = (rem_sh >= trial);
        diff   = rem_sh - trial;

        data_next       = data_in;
        data_next.rad   = {data_in.rad[ValW-3:0], 2'b00};
        data_next.rem   = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
        data_next.root  = {data_in.root[RootW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

>>> hw/rtl/perfect_square_remover_unit.sv
// Top level: square root cell chain, list counters and result register.
// An accepted request passes through the 16 root cells and then the result
// register; squares that are not last give no result.
// Throughput: one request per cycle; the whole chain stalls together while
// the result register holds a request that has not been taken.
// Reset (rst_n, asynchronous, active low) empties the chain and the result
// register and clears both list counters.
module perfect_square_remover_unit (
    input logic         clk,
    input logic         rst_n,
    psr_item_if.sink    items,
    psr_result_if.source results
);
    import psr_pkg::*;

    // Cell chain: stage k holds the request after k root digits.
    logic       cell_valid [NumCells+1];
    cell_data_t cell_data  [NumCells+1];
    logic       adv;

    // Result register
    logic               out_valid_reg;
    logic signed [31:0] value_out_reg;
    logic               has_value_reg;
    logic               end_reg;
    logic [CntW-1:0]    removed_total_reg;
    logic               none_left_reg;

    // List counters
    logic [CntW-1:0] kept_reg;
    logic [CntW-1:0] kept_next;
    logic [CntW-1:0] removed_reg;
    logic [CntW-1:0] removed_next;
    logic [CntW-1:0] kept_inc;
    logic [CntW-1:0] removed_inc;

    cell_data_t tail;
    logic       tail_valid;
    logic       tail_sq;
    logic       emit;

    // The chain moves whenever the result register is free or being emptied.
    assign adv          = !out_valid_reg || results.ready;
    assign items.ready  = adv;

    always_comb
    begin
        cell_data[0]       = '0;
        cell_data[0].value = items.value;
        cell_data[0].last  = items.last;
        cell_data[0].neg   = items.value[ValW-1];
        cell_data[0].rad   = items.value;
        cell_valid[0]      = items.valid;
    end

    for (genvar k = 0; k < NumCells; k++)
    begin : g_cell
        psr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (cell_valid[k]),
            .data_in   (cell_data[k]),
            .valid_out (cell_valid[k+1]),
            .data_out  (cell_data[k+1])
        );
    end

    assign tail       = cell_data[NumCells];
    assign tail_valid = cell_valid[NumCells];

    // Negative values are never squares; otherwise an exact root leaves no remainder.
    assign tail_sq = !tail.neg && (tail.rem == '0);
    assign emit    = tail_valid && (!tail_sq || tail.last);

    // Saturating counters, updated as each request leaves the chain.
    always_comb
    begin
        kept_inc     = (kept_reg >= CntW'(CountCap)) ? CntW'(CountCap) : kept_reg + 1'b1;
        removed_inc  = (removed_reg >= CntW'(CountCap)) ? CntW'(CountCap)
                                                         : removed_reg + 1'b1;
        kept_next    = tail_sq ? kept_reg : kept_inc;
        removed_next = tail_sq ? removed_inc : removed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg      <= '0;
            removed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= emit;
            if (tail_valid)
            begin
                if (tail.last)
                begin
                    // list done: start afresh
                    kept_reg    <= '0;
                    removed_reg <= '0;
                end
                else
                begin
                    kept_reg    <= kept_next;
                    removed_reg <= removed_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_out_reg     <= tail_sq ? '0 : tail.value;
            has_value_reg     <= !tail_sq;
            end_reg           <= tail.last;
            removed_total_reg <= tail.last ? removed_next : '0;
            none_left_reg     <= tail.last && (kept_next == '0);
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.value_out     = value_out_reg;
    assign results.has_value     = has_value_reg;
    assign results.end_of_list   = end_reg;
    assign results.removed_total = removed_total_reg;
    assign results.none_left     = none_left_reg;

endmodule
